>>> sv/assert_macros.svh
// Assertion macros shared by the averager RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset
`define BVA_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a same-cycle implication
`define BVA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check a next-cycle implication
`define BVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/bva_pkg.sv
// Package with widths, register codes and ALU control types for the averager
`timescale 1ns / 1ps
`default_nettype none

package bva_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int RATIO_W    = 22;
    localparam int OFFSET_W   = 14;
    localparam int MV_W       = 16;
    localparam int Q_SHIFT    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;

    localparam int SAMPLES_PER_BLOCK_DEF = 20;
    localparam int WINDOW_BLOCKS_DEF     = 10;

    localparam logic [MV_W-1:0]     MV_MAX       = 16'hFFFF;
    localparam logic [RATIO_W-1:0]  RATIO_RESET  = 22'd506542;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 14'd9000;

    localparam logic [CFG_IDX_W-1:0] REG_RATIO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;

    typedef logic [1:0] t_alu_op;

    localparam t_alu_op ALU_HOLD = 2'd0;
    localparam t_alu_op ALU_CLR  = 2'd1;
    localparam t_alu_op ALU_ADD  = 2'd2;
    localparam t_alu_op ALU_LOAD = 2'd3;

endpackage

`default_nettype wire

>>> sv/bva_alu.sv
// Shared accumulator with one adder for ring sums and the offset addition, plus clear and direct load
`timescale 1ns / 1ps
`default_nettype none

module bva_alu #(
    parameter int AW = 22
) (
    input  wire logic             i_clk,
    input  wire bva_pkg::t_alu_op i_ctl,
    input  wire logic [AW-1:0]    i_operand,
    output logic [AW-1:0]         o_acc
);

    logic [AW-1:0] r_acc;
    logic [AW-1:0] n_acc;
    logic [AW-1:0] w_sum;

    assign w_sum = r_acc + i_operand;

    always_comb begin
        n_acc = r_acc;
        unique case (i_ctl)
            bva_pkg::ALU_CLR: begin
                n_acc = '0;
            end
            bva_pkg::ALU_ADD: begin
                n_acc = w_sum;
            end
            bva_pkg::ALU_LOAD: begin
                n_acc = i_operand;
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

>>> sv/battery_voltage_averager_unit.sv
// Top level: sample ring, block average window, scaling and output register
//
//  channel  direction  handshake               payload
//  in       to block   i_in_valid/o_in_stall   i_sample_mv
//  out      from block i_out_stall/o_out_valid o_result_valid, o_battery_mv
//  cfg      to block   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A sample that does not wrap the ring is stored and gives an empty result. A wrapping
// sample runs the sequencer, which stalls the input until it returns to idle; the single
// adder in bva_alu sums both rings, and one shared multiplier scales the window sum and
// divides both averages by reciprocal multiplication.
// Synchronous active-low reset clears the sequencer, ring indices and window valid bits.
// A held output stalls the input side; configuration writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

module battery_voltage_averager_unit #(
    parameter int SAMPLES_PER_BLOCK = bva_pkg::SAMPLES_PER_BLOCK_DEF,
    parameter int WINDOW_BLOCKS     = bva_pkg::WINDOW_BLOCKS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [bva_pkg::SAMPLE_W-1:0]   i_sample_mv,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_result_valid,
    output logic [bva_pkg::MV_W-1:0]            o_battery_mv,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bva_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bva_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    `include "assert_macros.svh"

    localparam int SW    = bva_pkg::SAMPLE_W;
    localparam int SIW   = $clog2(SAMPLES_PER_BLOCK);
    localparam int WIW   = $clog2(WINDOW_BLOCKS);
    localparam int BSW   = SW + $clog2(SAMPLES_PER_BLOCK);
    localparam int WSW   = SW + $clog2(WINDOW_BLOCKS);
    localparam int PW    = bva_pkg::RATIO_W + WSW;
    localparam int AW    = PW - bva_pkg::Q_SHIFT;
    localparam int BLK_K = BSW + $clog2(SAMPLES_PER_BLOCK);
    localparam int BLK_M = (2 ** BLK_K + SAMPLES_PER_BLOCK - 1) / SAMPLES_PER_BLOCK;
    localparam int WIN_K = AW + $clog2(WINDOW_BLOCKS);
    localparam int WIN_M = (2 ** WIN_K + WINDOW_BLOCKS - 1) / WINDOW_BLOCKS;
    localparam int MW    = (AW + 1 > bva_pkg::RATIO_W) ? AW + 1 : bva_pkg::RATIO_W;
    localparam int MPW   = 2 * MW;
    localparam int DMAX  = (SAMPLES_PER_BLOCK > WINDOW_BLOCKS) ? SAMPLES_PER_BLOCK
                                                               : WINDOW_BLOCKS;
    localparam int CW    = $clog2(DMAX + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SSUM  = 4'd1;
    localparam logic [3:0] S_SMUL  = 4'd2;
    localparam logic [3:0] S_WWR   = 4'd3;
    localparam logic [3:0] S_WSUM  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_LOAD  = 4'd6;
    localparam logic [3:0] S_WMUL  = 4'd7;
    localparam logic [3:0] S_WLOAD = 4'd8;
    localparam logic [3:0] S_OFS   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]     r_state;
    logic [3:0]     n_state;
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  n_cnt;
    logic [SIW-1:0] r_sidx;
    logic [SIW-1:0] n_sidx;
    logic [WIW-1:0] r_widx;
    logic [WIW-1:0] n_widx;

    logic [bva_pkg::RATIO_W-1:0]  r_ratio;
    logic [bva_pkg::OFFSET_W-1:0] r_offset;

    logic [SW-1:0]            r_smem [SAMPLES_PER_BLOCK];
    logic [SW-1:0]            r_wmem [WINDOW_BLOCKS];
    logic [WINDOW_BLOCKS-1:0] r_wvld;
    logic [SW-1:0]            r_srd;
    logic [SW-1:0]            r_wrd;
    logic                     r_wrd_vld;
    logic [MPW-1:0]           r_prod;

    logic                    r_ovld;
    logic                    r_result_valid;
    logic [bva_pkg::MV_W-1:0] r_battery_mv;

    bva_pkg::t_alu_op  w_ctl;
    logic [AW-1:0]     w_operand;
    logic [AW-1:0]     w_acc;
    logic              w_in_acc;
    logic              w_out_free;
    logic              w_wrap;
    logic              w_out_load;
    logic [MW-1:0]     w_mul_a;
    logic [MW-1:0]     w_mul_b;
    logic [MPW-1:0]    w_prod;
    logic [SW-1:0]     w_blk_avg;

    assign w_out_free = !r_ovld || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && w_out_free);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_wrap     = (r_sidx == SIW'(SAMPLES_PER_BLOCK - 1));
    assign w_out_load = (r_state == S_OUT) && w_out_free;
    assign w_prod     = w_mul_a * w_mul_b;
    assign w_blk_avg  = SW'(r_prod >> BLK_K);
    assign o_cfg_ready = 1'b1;

    assign n_sidx = w_in_acc ? (w_wrap ? '0 : r_sidx + 1'b1) : r_sidx;
    assign n_widx = (r_state == S_WWR)
                  ? ((r_widx == WIW'(WINDOW_BLOCKS - 1)) ? '0 : r_widx + 1'b1)
                  : r_widx;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        w_ctl     = bva_pkg::ALU_HOLD;
        w_operand = '0;
        w_mul_a   = '0;
        w_mul_b   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_wrap) begin
                    n_state = S_SSUM;
                    n_cnt   = '0;
                    w_ctl   = bva_pkg::ALU_CLR;
                end
            end
            S_SSUM: begin
                n_cnt     = r_cnt + 1'b1;
                w_operand = {{(AW-SW){1'b0}}, r_srd};
                if (r_cnt != '0) begin
                    w_ctl = bva_pkg::ALU_ADD;
                end
                if (r_cnt == CW'(SAMPLES_PER_BLOCK)) begin
                    n_state = S_SMUL;
                    n_cnt   = '0;
                end
            end
            S_SMUL: begin
                w_mul_a = MW'(w_acc[BSW-1:0]);
                w_mul_b = MW'(BLK_M);
                n_state = S_WWR;
            end
            S_WWR: begin
                w_ctl   = bva_pkg::ALU_CLR;
                n_state = S_WSUM;
                n_cnt   = '0;
            end
            S_WSUM: begin
                n_cnt     = r_cnt + 1'b1;
                w_operand = r_wrd_vld ? {{(AW-SW){1'b0}}, r_wrd} : '0;
                if (r_cnt != '0) begin
                    w_ctl = bva_pkg::ALU_ADD;
                end
                if (r_cnt == CW'(WINDOW_BLOCKS)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                w_mul_a = MW'(r_ratio);
                w_mul_b = MW'(w_acc[WSW-1:0]);
                n_state = S_LOAD;
            end
            S_LOAD: begin
                w_ctl     = bva_pkg::ALU_LOAD;
                w_operand = AW'(r_prod >> bva_pkg::Q_SHIFT);
                n_state   = S_WMUL;
            end
            S_WMUL: begin
                w_mul_a = MW'(w_acc);
                w_mul_b = MW'(WIN_M);
                n_state = S_WLOAD;
            end
            S_WLOAD: begin
                w_ctl     = bva_pkg::ALU_LOAD;
                w_operand = AW'(r_prod >> WIN_K);
                n_state   = S_OFS;
            end
            S_OFS: begin
                w_ctl     = bva_pkg::ALU_ADD;
                w_operand = {{(AW-bva_pkg::OFFSET_W){1'b0}}, r_offset};
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    bva_alu #(
        .AW (AW)
    ) u_alu (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_operand (w_operand),
        .o_acc     (w_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sidx  <= '0;
            r_widx  <= '0;
            r_wvld  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sidx  <= n_sidx;
            r_widx  <= n_widx;
            if (r_state == S_WWR) begin
                r_wvld[r_widx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio  <= bva_pkg::RATIO_RESET;
            r_offset <= bva_pkg::OFFSET_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bva_pkg::REG_RATIO:  r_ratio  <= i_cfg_data[bva_pkg::RATIO_W-1:0];
                bva_pkg::REG_OFFSET: r_offset <= i_cfg_data[bva_pkg::OFFSET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_smem[r_sidx] <= i_sample_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_SSUM) && (r_cnt < CW'(SAMPLES_PER_BLOCK))) begin
            r_srd <= r_smem[r_cnt[SIW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WWR) begin
            r_wmem[r_widx] <= w_blk_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_WSUM) && (r_cnt < CW'(WINDOW_BLOCKS))) begin
            r_wrd     <= r_wmem[r_cnt[WIW-1:0]];
            r_wrd_vld <= r_wvld[r_cnt[WIW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_SMUL) || (r_state == S_MUL) || (r_state == S_WMUL)) begin
            r_prod <= w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if ((w_in_acc && !w_wrap) || w_out_load) begin
            r_ovld <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && !w_wrap) begin
            r_result_valid <= 1'b0;
            r_battery_mv   <= '0;
        end else if (w_out_load) begin
            r_result_valid <= 1'b1;
            r_battery_mv   <= (w_acc > AW'(bva_pkg::MV_MAX)) ? bva_pkg::MV_MAX
                                                             : w_acc[bva_pkg::MV_W-1:0];
        end
    end

    assign o_out_valid    = r_ovld;
    assign o_result_valid = r_result_valid;
    assign o_battery_mv   = r_battery_mv;

    `BVA_ASSERT_NEXT(a_short_item, i_clk, i_rst_n, w_in_acc && !w_wrap, r_ovld && !r_result_valid, "non-wrapping sample gave no empty result")
    `BVA_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, r_ovld && !r_result_valid, r_battery_mv == '0, "empty result carries a voltage")
    `BVA_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, (r_state == S_SSUM) || (r_state == S_WSUM), r_cnt <= CW'(DMAX), "sum step count out of range")
    `BVA_ASSERT_ALWAYS(a_busy_stall, i_clk, i_rst_n, (r_state == S_IDLE) || o_in_stall, "input taken while sequencer busy")

endmodule

`default_nettype wire
